// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on a rising edge and disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every enabled clock edge
`define SQA_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error("check failed");

// condition must never be true at an enabled clock edge
`define SQA_NEVER(lbl, ck, rstn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error("illegal condition");

`else

`define SQA_ASSERT(lbl, ck, rstn, prop)
`define SQA_NEVER(lbl, ck, rstn, cond)

`endif

`endif

// ===== rtl/sqa_pkg.sv =====
// ----------------------------------------------------------------------------
// sqa_pkg
// request and status codes, cell control and result types for the queue
// ----------------------------------------------------------------------------
package sqa_pkg;

  typedef enum logic [2:0] {
    REQ_ENQ    = 3'd0,
    REQ_DEQ    = 3'd1,
    REQ_LOCATE = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_REMOVE = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // locate scans the match bits SCAN_W (1 << SCAN_LOG) at a time
  localparam int SCAN_LOG = 3;
  localparam int SCAN_W   = 1 << SCAN_LOG;

  typedef struct packed {
    logic load;       // take the request value
    logic from_next;  // take the entry behind (close a gap)
    logic from_prev;  // take the entry ahead (open a gap)
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data_out;
    logic [4:0]         found_position;
    logic [4:0]         count;
  } result_t;

  // index of the lowest set bit in a scan group
  function automatic logic [SCAN_LOG-1:0] first_set(input logic [SCAN_W-1:0] bits);
    logic [SCAN_LOG-1:0] idx;
    idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (bits[i]) idx = SCAN_LOG'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/sqa_cell.sv =====
// ----------------------------------------------------------------------------
// sqa_cell
// one queue slot: holds a word, shifts with its neighbors, compares for locate
// ----------------------------------------------------------------------------
module sqa_cell (
  input  logic               clk,
  input  sqa_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] din,
  input  logic signed [31:0] prev_ent,
  input  logic signed [31:0] next_ent,
  output logic signed [31:0] ent,
  output logic               match
);

  logic signed [31:0] ent_r;
  logic signed [31:0] ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.load) begin
      ent_nxt = din;
    end else if (ctl.from_next) begin
      ent_nxt = next_ent;
    end else if (ctl.from_prev) begin
      ent_nxt = prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent   = ent_r;
  assign match = (ent_r == din);

endmodule

// ===== rtl/sqa_out_buf.sv =====
// ----------------------------------------------------------------------------
// sqa_out_buf
// two-entry result buffer: output register plus a skid register
// ----------------------------------------------------------------------------
module sqa_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sqa_pkg::result_t   push_res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output sqa_pkg::result_t   out_res
);

  logic             ov_r, ov_nxt;
  logic             sv_r, sv_nxt;
  sqa_pkg::result_t ores_r, ores_nxt;
  sqa_pkg::result_t sres_r, sres_nxt;

  always_comb begin
    ov_nxt   = ov_r;
    sv_nxt   = sv_r;
    ores_nxt = ores_r;
    sres_nxt = sres_r;
    if (!ov_r || out_ready) begin
      // output register free or draining this cycle
      ov_nxt = sv_r || push;
      if (sv_r) begin
        ores_nxt = sres_r;
        sv_nxt   = push;
        sres_nxt = push_res;
      end else begin
        ores_nxt = push_res;
      end
    end else if (push) begin
      sv_nxt   = 1'b1;
      sres_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= ores_nxt;
    sres_r <= sres_nxt;
  end

  assign room      = !sv_r;
  assign out_valid = ov_r;
  assign out_res   = ores_r;

endmodule

// ===== rtl/shifting_array_queue.sv =====
// ----------------------------------------------------------------------------
// shifting_array_queue
// ordered store of up to DEPTH signed words, packed from the head
// ----------------------------------------------------------------------------
// A request on the in_ channel enqueues, dequeues the head, locates a value,
// inserts at a 1-based position or removes at one. Each request gives one
// result on the out_ channel: status, removed data, found position, count.
// The store is a row of cells, one per entry; dequeue, insert and remove
// shift the cells from the addressed slot on when the request is taken.
// Enqueue, dequeue, insert and remove finish as they are taken: a new
// request can be taken every cycle while in_ready is high, and its result
// is registered in the result buffer. Locate registers the per-cell compare
// bits, then scans them eight per cycle, stopping early on a hit, and
// in_ready stays low while the scan runs.
// Results go through a two-entry buffer, so one request is still taken while
// a result waits; a stalled receiver fills the buffer and then in_ready drops.
// Reset empties the store (count zero) and the result buffer; entry contents
// are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shifting_array_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_data_in,
  input  logic [4:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_data_out,
  output logic [4:0]         out_found_position,
  output logic [4:0]         out_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = ((CW > 5) ? CW : 5) + 1;
  localparam int NGRP = (DEPTH + sqa_pkg::SCAN_W - 1) / sqa_pkg::SCAN_W;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int MW   = NGRP * sqa_pkg::SCAN_W;
  localparam int FW   = GW + sqa_pkg::SCAN_LOG + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t           st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [GW-1:0]    grp_r, grp_nxt;
  logic [MW-1:0]    loc_match_r;
  logic [MW-1:0]    match_vec;

  logic             in_fire;
  logic             buf_room;
  logic             full, empty;
  logic [PW-1:0]    pos_w, cnt_w, tgt_w;
  logic             ins_bad, rem_bad;
  logic             do_enq, do_ins, do_del, is_locate;
  logic signed [31:0] del_data;

  sqa_pkg::cell_ctl_t ctl      [DEPTH];
  logic signed [31:0] ent      [DEPTH];
  logic signed [31:0] prev_d   [DEPTH];
  logic signed [31:0] next_d   [DEPTH];
  logic               cell_hit [DEPTH];

  sqa_pkg::result_t acc_res, scan_res, push_res, buf_res;
  logic             push, scan_done;
  logic [sqa_pkg::SCAN_W-1:0] grp_bits;
  logic [FW-1:0]    found_sum;

  assign in_ready = (st_r == S_IDLE) && buf_room;
  assign in_fire  = in_valid && in_ready;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign pos_w = PW'(in_position);
  assign cnt_w = PW'(cnt_r);

  assign ins_bad = (in_position == '0) || (pos_w > cnt_w + PW'(1));
  assign rem_bad = (in_position == '0) || (pos_w > cnt_w);

  assign is_locate = in_fire && (in_req_type == sqa_pkg::REQ_LOCATE);
  assign do_enq = in_fire && (in_req_type == sqa_pkg::REQ_ENQ) && !full;
  assign do_ins = in_fire && (in_req_type == sqa_pkg::REQ_INSERT) && !full && !ins_bad;
  assign do_del = in_fire && !empty &&
                  ((in_req_type == sqa_pkg::REQ_DEQ) ||
                   ((in_req_type == sqa_pkg::REQ_REMOVE) && !rem_bad));
  // slot addressed by dequeue, insert or remove
  assign tgt_w = (in_req_type == sqa_pkg::REQ_DEQ) ? '0 : pos_w - PW'(1);

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(i);

    if (i == 0) begin : g_head
      assign prev_d[i] = '0;
    end else begin : g_mid_p
      assign prev_d[i] = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_d[i] = '0;
    end else begin : g_mid_n
      assign next_d[i] = ent[i+1];
    end

    assign ctl[i].load      = (do_enq && (IDX == cnt_w)) || (do_ins && (IDX == tgt_w));
    assign ctl[i].from_prev = do_ins && (IDX > tgt_w) && (IDX <= cnt_w);
    assign ctl[i].from_next = do_del && (IDX >= tgt_w) && (IDX + PW'(1) < cnt_w);

    sqa_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .din      (in_data_in),
      .prev_ent (prev_d[i]),
      .next_ent (next_d[i]),
      .ent      (ent[i]),
      .match    (cell_hit[i])
    );
  end

  // value leaving the store on dequeue or remove, and match bits of occupied cells
  always_comb begin
    del_data  = '0;
    match_vec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (PW'(i) == tgt_w) del_data = del_data | ent[i];
      match_vec[i] = cell_hit[i] && (PW'(i) < cnt_w);
    end
  end

  // result and new count for enqueue, dequeue, insert and remove requests
  always_comb begin
    cnt_nxt = cnt_r;
    acc_res = '{status: sqa_pkg::ST_OK, data_out: '0, found_position: '0, count: '0};
    case (in_req_type)
      sqa_pkg::REQ_ENQ: begin
        if (full) acc_res.status = sqa_pkg::ST_FULL;
      end
      sqa_pkg::REQ_DEQ: begin
        if (empty) acc_res.status = sqa_pkg::ST_EMPTY;
      end
      sqa_pkg::REQ_INSERT: begin
        if (full) begin
          acc_res.status = sqa_pkg::ST_FULL;
        end else if (ins_bad) begin
          acc_res.status = sqa_pkg::ST_BADPOS;
        end
      end
      sqa_pkg::REQ_REMOVE: begin
        if (empty) begin
          acc_res.status = sqa_pkg::ST_EMPTY;
        end else if (rem_bad) begin
          acc_res.status = sqa_pkg::ST_BADPOS;
        end
      end
      default: begin
      end
    endcase
    if (do_enq || do_ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_del) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (do_del) acc_res.data_out = del_data;
    acc_res.count = 5'(cnt_nxt);
  end

  // locate scan over registered match bits
  assign grp_bits  = loc_match_r[grp_r * sqa_pkg::SCAN_W +: sqa_pkg::SCAN_W];
  assign found_sum = {1'b0, grp_r, sqa_pkg::first_set(grp_bits)} + FW'(1);
  assign scan_done = (st_r == S_SCAN) && ((|grp_bits) || (grp_r == GW'(NGRP - 1)));

  always_comb begin
    scan_res = '{status: sqa_pkg::ST_NOTFOUND, data_out: '0, found_position: '0,
                 count: 5'(cnt_r)};
    if (|grp_bits) begin
      scan_res.status         = sqa_pkg::ST_OK;
      scan_res.found_position = found_sum[4:0];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    grp_nxt = grp_r;
    unique case (st_r)
      S_IDLE: begin
        grp_nxt = '0;
        if (is_locate) st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          st_nxt = S_IDLE;
        end else begin
          grp_nxt = grp_r + GW'(1);
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      grp_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      grp_r <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_locate) loc_match_r <= match_vec;
  end

  assign push     = (in_fire && !is_locate) || scan_done;
  assign push_res = scan_done ? scan_res : acc_res;

  sqa_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .room      (buf_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (buf_res)
  );

  assign out_status         = buf_res.status;
  assign out_data_out       = buf_res.data_out;
  assign out_found_position = buf_res.found_position;
  assign out_count          = buf_res.count;

  `SQA_NEVER(a_cnt_range, clk, rst_n, cnt_r > CW'(DEPTH))
  `SQA_ASSERT(a_cnt_hold, clk, rst_n, !in_fire |=> $stable(cnt_r))
  `SQA_ASSERT(a_locate_scan, clk, rst_n, is_locate |=> (st_r == S_SCAN))
  `SQA_NEVER(a_buf_overflow, clk, rst_n, push && !buf_room && !(out_valid && out_ready))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for shifting_array_queue: a short opening sequence of
// requests covers the empty, full and bad-position corners, then a long
// random run moves the fill level up and down while a shadow queue in the
// bench predicts status, removed data, found position and count per request
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH       = 16;
  localparam int N_RANDOM    = 1400;
  localparam int TAIL_CYCLES = 20;
  localparam int IDLE_LIMIT  = 2000;
  localparam int N_OPENING   = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = 3'd0;
  logic signed [31:0] in_data_in = 32'sd0;
  logic [4:0]         in_position = 5'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_data_out;
  logic [4:0]         out_found_position;
  logic [4:0]         out_count;

  shifting_array_queue #(.DEPTH(DEPTH)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_data_in         (in_data_in),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_data_out       (out_data_out),
    .out_found_position (out_found_position),
    .out_count          (out_count)
  );

  always #4 clk = ~clk;

  // shadow copy of the stored entries, head at index 0
  logic signed [31:0] shadow[$];
  sqa_pkg::result_t   pending_results[$];
  int                 mismatches = 0;

  typedef struct {
    logic [2:0]         req;
    logic signed [31:0] data;
    logic [4:0]         pos;
    int                 reps;    // data steps by one on each repeat
    bit                 typed;   // take want as is instead of the prediction
    sqa_pkg::result_t   want;
  } op_row_t;

  op_row_t opening_ops [N_OPENING] = '{
    '{sqa_pkg::REQ_DEQ, 32'h0, 5'd0, 1, 1'b1, '{sqa_pkg::ST_EMPTY, 32'h0, 5'd0, 5'd0}},
    '{sqa_pkg::REQ_REMOVE, 32'h0, 5'd0, 1, 1'b1, '{sqa_pkg::ST_EMPTY, 32'h0, 5'd0, 5'd0}},
    '{sqa_pkg::REQ_LOCATE, 32'h0, 5'd0, 1, 1'b1, '{sqa_pkg::ST_NOTFOUND, 32'h0, 5'd0, 5'd0}},
    '{sqa_pkg::REQ_INSERT, 32'h5, 5'd0, 1, 1'b1, '{sqa_pkg::ST_BADPOS, 32'h0, 5'd0, 5'd0}},
    '{sqa_pkg::REQ_INSERT, 32'h5, 5'd2, 1, 1'b1, '{sqa_pkg::ST_BADPOS, 32'h0, 5'd0, 5'd0}},
    '{sqa_pkg::REQ_INSERT, 32'h8000_0000, 5'd1, 1, 1'b1, '{sqa_pkg::ST_OK, 32'h0, 5'd0, 5'd1}},
    '{sqa_pkg::REQ_ENQ, 32'h7FFF_FFFF, 5'd0, 1, 1'b1, '{sqa_pkg::ST_OK, 32'h0, 5'd0, 5'd2}},
    '{sqa_pkg::REQ_INSERT, 32'hFFFF_FFFF, 5'd2,  1,  1'b0, '0},
    '{sqa_pkg::REQ_INSERT, 32'h0000_0000, 5'd4,  1,  1'b0, '0},
    '{sqa_pkg::REQ_LOCATE, 32'h7FFF_FFFF, 5'd0,  1,  1'b0, '0},
    '{sqa_pkg::REQ_REMOVE, 32'h0000_0000, 5'd5,  1,  1'b0, '0},
    '{sqa_pkg::REQ_REMOVE, 32'h0000_0000, 5'd0,  1,  1'b0, '0},
    '{sqa_pkg::REQ_REMOVE, 32'h0000_0000, 5'd2,  1,  1'b0, '0},
    '{3'd5,                32'hFFFF_FFFF, 5'd31, 1,  1'b0, '0},
    '{sqa_pkg::REQ_ENQ,    32'h5555_0000, 5'd0,  13, 1'b0, '0},
    '{sqa_pkg::REQ_ENQ,    32'h0000_0001, 5'd0,  1,  1'b0, '0},
    '{sqa_pkg::REQ_INSERT, 32'h0000_0001, 5'd0,  1,  1'b0, '0},
    '{sqa_pkg::REQ_LOCATE, 32'h5555_000C, 5'd0,  1,  1'b0, '0},
    '{sqa_pkg::REQ_REMOVE, 32'h0000_0000, 5'd16, 1,  1'b0, '0},
    '{sqa_pkg::REQ_DEQ,    32'h0000_0000, 5'd0,  1,  1'b0, '0}
  };

  // updates the shadow store and returns the result the request should give
  function automatic sqa_pkg::result_t apply_request(input logic [2:0] rt,
                                                     input logic signed [31:0] d,
                                                     input logic [4:0] p);
    sqa_pkg::result_t r;
    int               pi;
    int               fill;
    r = '0;
    r.status = sqa_pkg::ST_OK;
    pi = int'(p);
    fill = shadow.size();
    case (rt)
      sqa_pkg::REQ_ENQ: begin
        if (fill >= DEPTH) r.status = sqa_pkg::ST_FULL;
        else shadow.push_back(d);
      end
      sqa_pkg::REQ_DEQ: begin
        if (fill == 0) r.status = sqa_pkg::ST_EMPTY;
        else r.data_out = shadow.pop_front();
      end
      sqa_pkg::REQ_LOCATE: begin
        r.status = sqa_pkg::ST_NOTFOUND;
        for (int i = 0; i < fill; i++) begin
          if (shadow[i] == d) begin
            r.status = sqa_pkg::ST_OK;
            r.found_position = 5'(i + 1);
            break;
          end
        end
      end
      sqa_pkg::REQ_INSERT: begin
        // full wins over a bad position
        if (fill >= DEPTH) r.status = sqa_pkg::ST_FULL;
        else if (pi < 1 || pi > fill + 1) r.status = sqa_pkg::ST_BADPOS;
        else shadow.insert(pi - 1, d);
      end
      sqa_pkg::REQ_REMOVE: begin
        // empty wins over a bad position
        if (fill == 0) r.status = sqa_pkg::ST_EMPTY;
        else if (pi < 1 || pi > fill) r.status = sqa_pkg::ST_BADPOS;
        else begin
          r.data_out = shadow[pi - 1];
          shadow.delete(pi - 1);
        end
      end
      default: ;
    endcase
    r.count = 5'(shadow.size());
    return r;
  endfunction

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_request(input logic [2:0] rt, input logic signed [31:0] d,
                              input logic [4:0] p, input bit typed,
                              input sqa_pkg::result_t want);
    sqa_pkg::result_t predicted;
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_data_in  <= d;
    in_position <= p;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(rt, d, p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // receiver: changes its stall pattern every so often, with long stalls now and then
  int rdy_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
      if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 30);
    end else begin
      mode_left = mode_left - 1;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rdy_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (mode_left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    sqa_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data_out %0d found_position %0d count %0d",
               out_status, out_data_out, out_found_position, out_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_data_out !== want.data_out) begin
          $error("data_out: expected %0d, got %0d", want.data_out, out_data_out);
          mismatches++;
        end
        if (out_found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, out_found_position);
          mismatches++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          mismatches++;
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0]         rt;
    logic signed [31:0] d;
    logic [4:0]         p;
    int                 pick;
    int                 grow_pct;
    int                 phase_left;
    int                 burst_left;
    int                 n_done;
    bit                 drained;

    grow_pct   = 50;
    phase_left = 0;
    burst_left = 0;
    n_done     = 0;
    drained    = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // opening sequence back to back
    foreach (opening_ops[r]) begin
      for (int k = 0; k < opening_ops[r].reps; k++) begin
        send_request(opening_ops[r].req, opening_ops[r].data + k, opening_ops[r].pos,
                     opening_ops[r].typed, opening_ops[r].want);
      end
    end

    while (n_done < N_RANDOM) begin
      // fill phases push toward full, drain phases toward empty
      if (phase_left == 0) begin
        pick = $urandom_range(0, 2);
        grow_pct = (pick == 0) ? 78 : (pick == 1) ? 50 : 22;
        phase_left = $urandom_range(40, 150);
      end
      phase_left--;

      pick = $urandom_range(0, 99);
      if (pick < 2) rt = 3'($urandom_range(5, 7));
      else if (pick < 20) rt = sqa_pkg::REQ_LOCATE;
      else if ($urandom_range(0, 99) < grow_pct)
        rt = $urandom_range(0, 1) ? sqa_pkg::REQ_ENQ : sqa_pkg::REQ_INSERT;
      else
        rt = $urandom_range(0, 1) ? sqa_pkg::REQ_DEQ : sqa_pkg::REQ_REMOVE;

      if (rt == sqa_pkg::REQ_LOCATE && shadow.size() != 0 && $urandom_range(0, 9) < 7)
        d = shadow[$urandom_range(0, shadow.size() - 1)];
      else if ($urandom_range(0, 1))
        d = 32'($urandom_range(0, 15)) - 32'sd8;  // small pool makes duplicates
      else
        d = $urandom;

      if ($urandom_range(0, 4) == 0 || shadow.size() == 0)
        p = 5'($urandom_range(0, 31));
      else if (rt == sqa_pkg::REQ_INSERT)
        p = 5'($urandom_range(1, shadow.size() + 1));
      else
        p = 5'($urandom_range(1, shadow.size()));

      // sender idles between bursts
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 30);
      end
      burst_left--;

      send_request(rt, d, p, 1'b0, '0);
      if (rt <= 3'(sqa_pkg::REQ_REMOVE)) n_done++;

      // hold off once until the block has delivered everything
      if (!drained && n_done >= N_RANDOM / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        burst_left = 0;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sqa_pkg.sv
rtl/sqa_cell.sv
rtl/sqa_out_buf.sv
rtl/shifting_array_queue.sv
tb/tb_top.sv
